[rtl/accc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accc_pkg
// Shared constants, command codes, status struct and arithmetic helpers for
// the affine cycle closure checker.
// ----------------------------------------------------------------------------
package accc_pkg;

	localparam int unsigned MODULUS = 768;
	localparam int unsigned VAL_W   = 10;
	localparam int unsigned PROD_W  = 2 * VAL_W;
	localparam int unsigned K_W     = 4;
	localparam int unsigned SH_W    = 2 * VAL_W - 1;
	localparam int unsigned T_W     = 13;
	localparam int unsigned T_SH_W  = T_W + VAL_W - 1;

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [K_W-1:0]    shamt_t;

	localparam val_t MOD_V = val_t'(MODULUS);

	// Datapath commands
	typedef logic [3:0] cmd_t;
	localparam cmd_t CMD_NOP      = 4'd0;
	localparam cmd_t CMD_CAPTURE  = 4'd1;
	localparam cmd_t CMD_LOAD_INV = 4'd2;
	localparam cmd_t CMD_LOAD_GCD = 4'd3;
	localparam cmd_t CMD_LOAD_MOD = 4'd4;
	localparam cmd_t CMD_DIV_STEP = 4'd5;
	localparam cmd_t CMD_INV_FIX  = 4'd6;
	localparam cmd_t CMD_SET_ERR  = 4'd7;
	localparam cmd_t CMD_MUL_INV  = 4'd8;
	localparam cmd_t CMD_NEG_B    = 4'd9;
	localparam cmd_t CMD_MUL_B    = 4'd10;
	localparam cmd_t CMD_RED_B    = 4'd11;
	localparam cmd_t CMD_MUL_A    = 4'd12;
	localparam cmd_t CMD_RED_A    = 4'd13;
	localparam cmd_t CMD_EMIT     = 4'd14;

	typedef struct packed {
		logic r1_zero;
		logic r0_one;
		logic k_zero;
		logic invert;
		logic cycle_end;
	} dp_status_t;

	// Position of the leading one; zero for a zero operand.
	function automatic shamt_t msb_pos(input val_t x);
		shamt_t p;
		p = '0;
		for (int i = 0; i < VAL_W; i++) begin
			if (x[i]) begin
				p = shamt_t'(i);
			end
		end
		return p;
	endfunction

	// First quotient bit position for a shift-subtract division of r0 by r1.
	function automatic shamt_t start_shift(input val_t r0, input val_t r1);
		shamt_t p0;
		shamt_t p1;
		p0 = msb_pos(r0);
		p1 = msb_pos(r1);
		return (p0 > p1) ? shamt_t'(p0 - p1) : '0;
	endfunction

	// Residue mod 3 by folding base-4 digits (4 is 1 mod 3).
	function automatic logic [1:0] mod3_12(input logic [11:0] x);
		logic [4:0] s;
		logic [2:0] s2;
		logic [2:0] s3;
		s = '0;
		for (int i = 0; i < 6; i++) begin
			s = s + 5'(x[2*i +: 2]);
		end
		s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		s3 = 3'(s2[1:0]) + 3'(s2[2]);
		if (s3 >= 3'd3) begin
			s3 = s3 - 3'd3;
		end
		return s3[1:0];
	endfunction

	// Product reduction mod 768 = 3 * 256: low byte passes, upper part mod 3.
	function automatic val_t reduce_prod(input prod_t x);
		return {mod3_12(x[PROD_W-1:8]), x[7:0]};
	endfunction

	// Input fields are below twice the modulus.
	function automatic val_t reduce_in(input val_t x);
		return (x >= MOD_V) ? val_t'(x - MOD_V) : x;
	endfunction

endpackage

[rtl/accc_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accc_dpath
// Datapath: input capture, running affine composition, shared multiplier with
// mod reduction, and a shift-subtract extended Euclid unit reused for the
// inverse, the gcd and the final divisibility test.
// ----------------------------------------------------------------------------
module accc_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  accc_pkg::cmd_t      cmd,
	input  accc_pkg::val_t      map_a,
	input  accc_pkg::val_t      map_b,
	input  logic                invert,
	input  logic                cycle_end,
	output accc_pkg::dp_status_t status,
	output logic                closed,
	output accc_pkg::val_t      composed_a,
	output accc_pkg::val_t      composed_b,
	output logic                not_invertible
);
	import accc_pkg::*;

	localparam logic signed [T_W-1:0] T_MOD = T_W'(MODULUS);

	val_t fa_q;
	val_t fb_q;
	logic inv_q;
	logic end_q;
	val_t acc_mult_q;
	val_t acc_offset_q;
	logic err_q;
	prod_t prod_q;

	val_t r0_q;
	val_t r1_q;
	logic signed [T_W-1:0] t0_q;
	logic signed [T_W-1:0] t1_q;
	shamt_t k_q;

	logic closed_q;
	val_t comp_a_q;
	val_t comp_b_q;
	logic not_inv_q;

	logic [SH_W-1:0] sh_r1;
	logic take;
	val_t rem;
	logic signed [T_SH_W-1:0] t1_sh;
	logic signed [T_SH_W-1:0] t_diff;
	logic signed [T_W-1:0] t0_new;
	logic signed [T_W-1:0] t_fix;
	val_t gcd_x;
	val_t mul_x;
	val_t mul_y;
	prod_t prod_d;
	prod_t sum_b;
	val_t red_b;
	val_t red_p;

	// One quotient digit per cycle; cofactor follows the same subtraction.
	always_comb begin
		sh_r1  = SH_W'(r1_q) << k_q;
		take   = (sh_r1 <= SH_W'(r0_q));
		rem    = take ? val_t'(r0_q - sh_r1[VAL_W-1:0]) : r0_q;
		t1_sh  = T_SH_W'(t1_q) <<< k_q;
		t_diff = T_SH_W'(t0_q) - t1_sh;
		t0_new = take ? T_W'(t_diff) : t0_q;
	end

	always_comb begin
		if (t0_q < 0) begin
			t_fix = t0_q + T_MOD;
		end else if (t0_q >= T_MOD) begin
			t_fix = t0_q - T_MOD;
		end else begin
			t_fix = t0_q;
		end
	end

	assign gcd_x = (acc_mult_q == '0) ? val_t'(MOD_V - 1'b1) : val_t'(acc_mult_q - 1'b1);

	always_comb begin
		case (cmd)
			CMD_MUL_INV: begin
				mul_x = fa_q;
				mul_y = fb_q;
			end
			CMD_MUL_B: begin
				mul_x = acc_mult_q;
				mul_y = fb_q;
			end
			default: begin
				mul_x = acc_mult_q;
				mul_y = fa_q;
			end
		endcase
	end

	assign prod_d = PROD_W'(mul_x) * PROD_W'(mul_y);
	assign sum_b  = prod_q + PROD_W'(acc_offset_q);
	assign red_b  = reduce_prod(sum_b);
	assign red_p  = reduce_prod(prod_q);

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_mult_q   <= val_t'(1);
			acc_offset_q <= '0;
			err_q        <= 1'b0;
		end else begin
			unique case (cmd)
				CMD_SET_ERR: err_q        <= 1'b1;
				CMD_RED_B:   acc_offset_q <= red_b;
				CMD_RED_A:   acc_mult_q   <= red_p;
				CMD_EMIT: begin
					acc_mult_q   <= val_t'(1);
					acc_offset_q <= '0;
					err_q        <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_CAPTURE: begin
				fa_q  <= reduce_in(map_a);
				fb_q  <= reduce_in(map_b);
				inv_q <= invert;
				end_q <= cycle_end;
			end
			CMD_LOAD_INV: begin
				r0_q <= MOD_V;
				r1_q <= fa_q;
				t0_q <= '0;
				t1_q <= T_W'(1);
				k_q  <= start_shift(MOD_V, fa_q);
			end
			CMD_LOAD_GCD: begin
				r0_q <= MOD_V;
				r1_q <= gcd_x;
				k_q  <= start_shift(MOD_V, gcd_x);
			end
			CMD_LOAD_MOD: begin
				r0_q <= acc_offset_q;
				r1_q <= r0_q;
				k_q  <= start_shift(acc_offset_q, r0_q);
			end
			CMD_DIV_STEP: begin
				if (k_q == '0) begin
					// last digit: remainder becomes the new divisor
					r0_q <= r1_q;
					r1_q <= rem;
					t0_q <= t1_q;
					t1_q <= t0_new;
					k_q  <= start_shift(r1_q, rem);
				end else begin
					r0_q <= rem;
					t0_q <= t0_new;
					k_q  <= k_q - 1'b1;
				end
			end
			CMD_INV_FIX: fa_q <= val_t'(t_fix);
			CMD_MUL_INV, CMD_MUL_B, CMD_MUL_A: prod_q <= prod_d;
			CMD_NEG_B: fb_q <= (red_p == '0) ? '0 : val_t'(MOD_V - red_p);
			CMD_EMIT: begin
				closed_q  <= (r1_q == '0);
				comp_a_q  <= acc_mult_q;
				comp_b_q  <= acc_offset_q;
				not_inv_q <= err_q;
			end
			default: ;
		endcase
	end

	assign status.r1_zero   = (r1_q == '0);
	assign status.r0_one    = (r0_q == val_t'(1));
	assign status.k_zero    = (k_q == '0);
	assign status.invert    = inv_q;
	assign status.cycle_end = end_q;

	assign closed         = closed_q;
	assign composed_a     = comp_a_q;
	assign composed_b     = comp_b_q;
	assign not_invertible = not_inv_q;

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_EMIT |=> acc_mult_q == val_t'(1) && acc_offset_q == '0 && !err_q)
		else $error("accumulator not back to identity after result");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_DIV_STEP && k_q == '0 |=> r1_q < r0_q)
		else $error("division left a remainder not below the divisor");

	a_inverse_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_INV_FIX |=> fa_q < MOD_V)
		else $error("inverse multiplier out of range");

endmodule

[rtl/accc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accc_ctrl
// Controller: sequences capture, inverse, composition, closure test and
// result hand-off; owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module accc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  accc_pkg::dp_status_t status,
	output accc_pkg::cmd_t       cmd
);
	import accc_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_START    = 4'd1;
	localparam logic [3:0] S_CHK      = 4'd2;
	localparam logic [3:0] S_DIV      = 4'd3;
	localparam logic [3:0] S_INV_MUL  = 4'd4;
	localparam logic [3:0] S_INV_NEG  = 4'd5;
	localparam logic [3:0] S_RED_B    = 4'd6;
	localparam logic [3:0] S_MUL_A    = 4'd7;
	localparam logic [3:0] S_RED_A    = 4'd8;
	localparam logic [3:0] S_LOAD_GCD = 4'd9;
	localparam logic [3:0] S_EMIT     = 4'd10;
	localparam logic [3:0] S_MUL_B    = 4'd11;

	localparam logic [1:0] LOOP_INV = 2'd0;
	localparam logic [1:0] LOOP_GCD = 2'd1;
	localparam logic [1:0] LOOP_MOD = 2'd2;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] loop_q;
	logic [1:0] loop_d;
	logic       out_valid_q;
	logic       emit_go;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		loop_d  = loop_q;
		cmd     = CMD_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = CMD_CAPTURE;
					state_d = S_START;
				end
			end
			S_START: begin
				if (status.invert) begin
					cmd     = CMD_LOAD_INV;
					loop_d  = LOOP_INV;
					state_d = S_CHK;
				end else begin
					state_d = S_MUL_B;
				end
			end
			S_CHK: begin
				if (!status.r1_zero) begin
					state_d = S_DIV;
				end else if (loop_q == LOOP_INV) begin
					if (status.r0_one) begin
						cmd     = CMD_INV_FIX;
						state_d = S_INV_MUL;
					end else begin
						// non-unit: drop this node, flag the cycle
						cmd     = CMD_SET_ERR;
						state_d = status.cycle_end ? S_LOAD_GCD : S_IDLE;
					end
				end else begin
					cmd     = CMD_LOAD_MOD;
					loop_d  = LOOP_MOD;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd = CMD_DIV_STEP;
				if (status.k_zero) begin
					state_d = (loop_q == LOOP_MOD) ? S_EMIT : S_CHK;
				end
			end
			S_INV_MUL: begin
				cmd     = CMD_MUL_INV;
				state_d = S_INV_NEG;
			end
			S_INV_NEG: begin
				cmd     = CMD_NEG_B;
				state_d = S_MUL_B;
			end
			S_MUL_B: begin
				cmd     = CMD_MUL_B;
				state_d = S_RED_B;
			end
			S_RED_B: begin
				cmd     = CMD_RED_B;
				state_d = S_MUL_A;
			end
			S_MUL_A: begin
				cmd     = CMD_MUL_A;
				state_d = S_RED_A;
			end
			S_RED_A: begin
				cmd     = CMD_RED_A;
				state_d = status.cycle_end ? S_LOAD_GCD : S_IDLE;
			end
			S_LOAD_GCD: begin
				cmd     = CMD_LOAD_GCD;
				loop_d  = LOOP_GCD;
				state_d = S_CHK;
			end
			S_EMIT: begin
				// hold until the output register is free
				if (emit_go) begin
					cmd     = CMD_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loop_q      <= LOOP_INV;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			loop_q  <= loop_d;
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("result raised outside the emit step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_START)
		else $error("accepted transaction did not start processing");

	a_mod_ends_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && loop_q == LOOP_MOD && status.k_zero |=> state_q == S_EMIT)
		else $error("closure test did not reach the emit step");

endmodule

[rtl/affine_cycle_closure_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_cycle_closure_check
// Composes affine maps x -> a*x + b mod 768 along a cycle, optionally inverted,
// and on the cycle's last node reports the composed map and its closure.
// ----------------------------------------------------------------------------
// One node is processed at a time; a new node is accepted only once the last one is done.
// A plain node is captured, then composed by multiply and reduce steps for b and then for a.
// An inverted node first inverts a in the shift-subtract Euclid unit (one digit/cycle);
// a non-unit is dropped and flagged. A cycle-ending node then divides the composed offset
// by gcd(composed a - 1, modulus) in the same unit for the closure test.
// The output register frees the input side while a result waits.
// Reset: asynchronous, clears to the identity map with no error and no result.
module affine_cycle_closure_check (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  accc_pkg::val_t map_a,
	input  accc_pkg::val_t map_b,
	input  logic           invert,
	input  logic           cycle_end,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           closed,
	output accc_pkg::val_t composed_a,
	output accc_pkg::val_t composed_b,
	output logic           not_invertible
);
	import accc_pkg::*;

	cmd_t       cmd;
	dp_status_t status;

	accc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	accc_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.map_a          (map_a),
		.map_b          (map_b),
		.invert         (invert),
		.cycle_end      (cycle_end),
		.status         (status),
		.closed         (closed),
		.composed_a     (composed_a),
		.composed_b     (composed_b),
		.not_invertible (not_invertible)
	);

endmodule

[tb/affine_cycle_closure_check_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_cycle_closure_check_test
// Self-checking bench for the affine cycle closure checker. A table of
// directed nodes comes first, with a few results typed in by hand. Random
// cycles follow: mirrored chains that must close, chains of units, and
// noise. Untyped results are checked against a behavioral model of the map
// composition; both handshakes idle and stall at random, bar the last phase.
// ----------------------------------------------------------------------------
module affine_cycle_closure_check_test;

	import accc_pkg::*;

	localparam int M          = MODULUS;
	localparam int PHASE_LEN  = 542;
	localparam int DRAIN_WAIT = 100;
	localparam int CYCLE_CAP  = 1_000_000;

	typedef struct packed {
		val_t a;
		val_t b;
		logic inv;
		logic last;
	} node_t;

	typedef struct packed {
		logic closed;
		val_t comp_a;
		val_t comp_b;
		logic not_inv;
	} closure_t;

	typedef struct packed {
		node_t    n;
		logic     typed;
		closure_t want;
	} plan_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	val_t     map_a = '0;
	val_t     map_b = '0;
	logic     invert = 1'b0;
	logic     cycle_end = 1'b0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	logic     closed;
	val_t     composed_a;
	val_t     composed_b;
	logic     not_invertible;

	int unsigned snd_idle = 0;
	int unsigned rcv_idle = 0;
	int          mismatches = 0;
	int          cycle_cnt = 0;

	// running composition of the cycle being walked
	int chain_a = 1;
	int chain_b = 0;
	bit chain_err = 1'b0;

	closure_t closure_q[$];
	node_t    cycle_nodes[$];

	// hand-checked nodes; untyped rows are checked against the model
	plan_row_t plan [22] = '{
		'{'{10'd1,    10'd0,    1'b0, 1'b1}, 1'b1, '{1'b1, 10'd1,   10'd0,   1'b0}},
		'{'{10'd767,  10'd767,  1'b0, 1'b1}, 1'b1, '{1'b0, 10'd767, 10'd767, 1'b0}},
		'{'{10'd1023, 10'd1023, 1'b0, 1'b1}, 1'b1, '{1'b0, 10'd255, 10'd255, 1'b0}},
		'{'{10'd768,  10'd0,    1'b0, 1'b1}, 1'b1, '{1'b1, 10'd0,   10'd0,   1'b0}},
		'{'{10'd0,    10'd5,    1'b0, 1'b1}, 1'b1, '{1'b1, 10'd0,   10'd5,   1'b0}},
		'{'{10'd1,    10'd5,    1'b0, 1'b1}, 1'b1, '{1'b0, 10'd1,   10'd5,   1'b0}},
		'{'{10'd0,    10'd0,    1'b1, 1'b1}, 1'b1, '{1'b1, 10'd1,   10'd0,   1'b1}},
		'{'{10'd6,    10'd3,    1'b1, 1'b1}, 1'b1, '{1'b1, 10'd1,   10'd0,   1'b1}},
		'{'{10'd767,  10'd5,    1'b1, 1'b1}, 1'b1, '{1'b0, 10'd767, 10'd5,   1'b0}},
		'{'{10'd5,    10'd7,    1'b0, 1'b0}, 1'b0, '0},
		'{'{10'd5,    10'd7,    1'b1, 1'b1}, 1'b1, '{1'b1, 10'd1,   10'd0,   1'b0}},
		'{'{10'd6,    10'd1,    1'b1, 1'b0}, 1'b0, '0},
		'{'{10'd3,    10'd4,    1'b0, 1'b1}, 1'b1, '{1'b1, 10'd3,   10'd4,   1'b1}},
		'{'{10'd512,  10'd1000, 1'b1, 1'b0}, 1'b0, '0},
		'{'{10'd1000, 10'd1023, 1'b0, 1'b0}, 1'b0, '0},
		'{'{10'd7,    10'd700,  1'b1, 1'b0}, 1'b0, '0},
		'{'{10'd11,   10'd300,  1'b1, 1'b1}, 1'b0, '0},
		'{'{10'd769,  10'd770,  1'b1, 1'b0}, 1'b0, '0},
		'{'{10'd1,    10'd2,    1'b0, 1'b1}, 1'b1, '{1'b1, 10'd1,   10'd0,   1'b0}},
		'{'{10'd383,  10'd1,    1'b1, 1'b1}, 1'b0, '0},
		'{'{10'd682,  10'd341,  1'b0, 1'b0}, 1'b0, '0},
		'{'{10'd341,  10'd682,  1'b1, 1'b1}, 1'b0, '0}
	};

	affine_cycle_closure_check uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.map_a          (map_a),
		.map_b          (map_b),
		.invert         (invert),
		.cycle_end      (cycle_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.closed         (closed),
		.composed_a     (composed_a),
		.composed_b     (composed_b),
		.not_invertible (not_invertible)
	);

	always #5 clk = ~clk;

	function automatic int gcd_of(input int x, input int y);
		int r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// extended Euclid; returns 0 when a shares a factor with the modulus
	function automatic bit unit_inverse(input int a, output int ia);
		int r0, r1, t0, t1, q, rn, tn;
		r0 = M;
		r1 = a;
		t0 = 0;
		t1 = 1;
		ia = 0;
		while (r1 != 0) begin
			q  = r0 / r1;
			rn = r0 - q * r1;
			tn = t0 - q * t1;
			r0 = r1;
			r1 = rn;
			t0 = t1;
			t1 = tn;
		end
		if (r0 != 1) begin
			return 1'b0;
		end
		t0 = t0 % M;
		if (t0 < 0) begin
			t0 += M;
		end
		ia = t0;
		return 1'b1;
	endfunction

	// compose one node in front of the running map; emit on the last node
	task automatic advance_chain(input node_t n, output bit emit, output closure_t res);
		int fa, fb, ia, nb, d;
		bit use_map;
		fa = int'(n.a) % M;
		fb = int'(n.b) % M;
		use_map = 1'b1;
		emit = 1'b0;
		res = '0;
		if (n.inv) begin
			if (unit_inverse(fa, ia)) begin
				fb = (M - (ia * fb) % M) % M;
				fa = ia;
			end else begin
				chain_err = 1'b1;
				use_map = 1'b0;
			end
		end
		if (use_map) begin
			nb = (chain_a * fb + chain_b) % M;
			chain_a = (chain_a * fa) % M;
			chain_b = nb;
		end
		if (n.last) begin
			d = gcd_of((chain_a + M - 1) % M, M);
			res.closed  = (d != 0) && (chain_b % d == 0);
			res.comp_a  = val_t'(chain_a);
			res.comp_b  = val_t'(chain_b);
			res.not_inv = chain_err;
			emit = 1'b1;
			chain_a = 1;
			chain_b = 0;
			chain_err = 1'b0;
		end
	endtask

	function automatic val_t pick_unit();
		int v;
		do begin
			v = $urandom_range(M - 1);
		end while (v % 2 == 0 || v % 3 == 0);
		// sometimes use the unreduced encoding
		if (v + M <= 1023 && $urandom_range(7) == 0) begin
			v += M;
		end
		return val_t'(v);
	endfunction

	task automatic send_node(input node_t n, input bit typed, input closure_t want);
		bit emit;
		closure_t pred;
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		in_valid  <= 1'b1;
		map_a     <= n.a;
		map_b     <= n.b;
		invert    <= n.inv;
		cycle_end <= n.last;
		do @(posedge clk); while (!in_ready);
		advance_chain(n, emit, pred);
		if (emit) begin
			closure_q.push_back(typed ? want : pred);
		end
	endtask

	task automatic build_cycle();
		int kind, len;
		node_t n;
		cycle_nodes.delete();
		kind = $urandom_range(99);
		if (kind < 30) begin
			// walk out and back along the same units: must close to the identity
			len = $urandom_range(1, 3);
			for (int i = 0; i < len; i++) begin
				n = '{pick_unit(), val_t'($urandom_range(M - 1)), 1'($urandom_range(1)), 1'b0};
				cycle_nodes.push_back(n);
			end
			for (int i = len - 1; i >= 0; i--) begin
				n = cycle_nodes[i];
				n.inv = ~n.inv;
				cycle_nodes.push_back(n);
			end
		end else if (kind < 75) begin
			len = $urandom_range(1, 5);
			for (int i = 0; i < len; i++) begin
				n = '{pick_unit(), val_t'($urandom_range(M - 1)), 1'($urandom_range(1)), 1'b0};
				cycle_nodes.push_back(n);
			end
		end else begin
			len = $urandom_range(1, 4);
			for (int i = 0; i < len; i++) begin
				n = '{val_t'($urandom_range(1023)), val_t'($urandom_range(1023)),
					1'($urandom_range(1)), 1'b0};
				cycle_nodes.push_back(n);
			end
		end
		n = cycle_nodes.pop_back();
		n.last = 1'b1;
		cycle_nodes.push_back(n);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	// result side: check accepted transactions, stall at random
	always @(posedge clk) begin
		closure_t want;
		if (arst_n && out_valid && out_ready) begin
			if (closure_q.size() == 0) begin
				report_mismatch("result with none pending, composed_a", int'(composed_a), -1);
			end else begin
				want = closure_q.pop_front();
				if (closed !== want.closed)
					report_mismatch("closed", int'(closed), int'(want.closed));
				if (composed_a !== want.comp_a)
					report_mismatch("composed_a", int'(composed_a), int'(want.comp_a));
				if (composed_b !== want.comp_b)
					report_mismatch("composed_b", int'(composed_b), int'(want.comp_b));
				if (not_invertible !== want.not_inv)
					report_mismatch("not_invertible", int'(not_invertible), int'(want.not_inv));
			end
		end
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int sent;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		snd_idle = 8;
		rcv_idle = 79;
		for (int i = 0; i < $size(plan); i++) begin
			send_node(plan[i].n, plan[i].typed, plan[i].want);
		end

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					snd_idle = 8;
					rcv_idle = 79;
				end
				1: begin
					snd_idle = 79;
					rcv_idle = 8;
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
				end
			endcase
			sent = 0;
			while (sent < PHASE_LEN) begin
				build_cycle();
				foreach (cycle_nodes[i]) begin
					send_node(cycle_nodes[i], 1'b0, '0);
				end
				sent += cycle_nodes.size();
			end
		end
		in_valid <= 1'b0;

		// drain, then hold a while to catch stray results
		while (closure_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/accc_pkg.sv
rtl/accc_dpath.sv
rtl/accc_ctrl.sv
rtl/affine_cycle_closure_check.sv
tb/affine_cycle_closure_check_test.sv
